// ===== rtl/plipnr_pkg.sv =====
`timescale 1ns / 1ps
package plipnr_pkg;

  localparam int unsigned ShakeBit    = 7;
  localparam logic [15:0] HeaderLen   = 16'd14;
  localparam logic [7:0]  DrvAck      = 8'h01;
  localparam logic [7:0]  DrvHigh     = 8'h10;
  localparam logic [7:0]  DrvIdle     = 8'h00;

  localparam logic [15:0] SpinLimitRst  = 16'd500;
  localparam logic [15:0] MaxPayloadRst = 16'd1500;
  localparam logic [7:0]  ErrorLimitRst = 8'd100;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPIN_LIMIT  = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1,
    CFG_ERROR_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_LOW  = 2'd1,
    PH_WAIT_HIGH = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FS_LEN_LOW  = 2'd0,
    FS_LEN_HIGH = 2'd1,
    FS_BODY     = 2'd2,
    FS_CHECKSUM = 2'd3
  } field_e;

  // One result per request.
  typedef struct packed {
    logic [7:0] data_drive;
    logic [7:0] rx_byte;
    logic       byte_valid;
    logic       packet_end;
    logic       packet_error;
    logic       busy_res;
    logic       offline;
  } res_t;

  // Receiver status seen by the top level.
  typedef struct packed {
    logic busy;
    logic offline;
  } stat_t;

endpackage

// ===== rtl/plipnr_seq.sv =====
`timescale 1ns / 1ps
module plipnr_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plipnr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plipnr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            step_i,
  input  logic                            mode_i,
  input  logic [7:0]                      sample_i,
  output plipnr_pkg::res_t                res_o,
  output plipnr_pkg::stat_t               stat_o
);

  logic [15:0] spin_limit_q, max_payload_q;
  logic [7:0]  error_limit_q;

  plipnr_pkg::phase_e phase_q, phase_d;
  plipnr_pkg::field_e field_q, field_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] spin_q, spin_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] taken_q, taken_d;
  logic [7:0]  err_cnt_q, err_cnt_d;
  logic        offline_q, offline_d;
  logic [7:0]  drive_q, drive_d;

  logic        fail, ok_end, end_flag, valid_flag;
  logic [7:0]  rx_val;
  logic [7:0]  rx_byte;
  logic [15:0] spin_dec;
  logic [15:0] taken_inc;
  logic [15:0] plen_full;
  logic [16:0] plen_limit;
  logic [8:0]  err_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_limit_q  <= plipnr_pkg::SpinLimitRst;
      max_payload_q <= plipnr_pkg::MaxPayloadRst;
      error_limit_q <= plipnr_pkg::ErrorLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plipnr_pkg::CFG_SPIN_LIMIT:  spin_limit_q  <= cfg_data_i;
        plipnr_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        plipnr_pkg::CFG_ERROR_LIMIT: error_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign rx_byte    = {sample_i[6:3], low_q[6:3]};
  assign spin_dec   = spin_q - 16'd1;
  assign taken_inc  = taken_q + 16'd1;
  assign plen_full  = {rx_byte, plen_q[7:0]};
  assign plen_limit = {1'b0, max_payload_q} + {1'b0, plipnr_pkg::HeaderLen};
  assign err_inc    = {1'b0, err_cnt_q} + 9'd1;

  always_comb begin
    phase_d    = phase_q;
    field_d    = field_q;
    low_d      = low_q;
    spin_d     = spin_q;
    plen_d     = plen_q;
    taken_d    = taken_q;
    err_cnt_d  = err_cnt_q;
    offline_d  = offline_q;
    drive_d    = drive_q;
    fail       = 1'b0;
    ok_end     = 1'b0;
    valid_flag = 1'b0;
    rx_val     = 8'h00;

    if (mode_i) begin
      if (phase_q == plipnr_pkg::PH_IDLE && !offline_q) begin
        drive_d = plipnr_pkg::DrvAck;
        field_d = plipnr_pkg::FS_LEN_LOW;
        plen_d  = 16'd0;
        taken_d = 16'd0;
        phase_d = plipnr_pkg::PH_WAIT_LOW;
        spin_d  = spin_limit_q;
      end
    end else begin
      unique case (phase_q)
        plipnr_pkg::PH_WAIT_LOW: begin
          if (!sample_i[plipnr_pkg::ShakeBit]) begin
            low_d   = sample_i;
            drive_d = plipnr_pkg::DrvHigh;
            phase_d = plipnr_pkg::PH_WAIT_HIGH;
          end else begin
            spin_d = spin_dec;
            fail   = (spin_dec == 16'd0);
          end
        end
        plipnr_pkg::PH_WAIT_HIGH: begin
          if (sample_i[plipnr_pkg::ShakeBit]) begin
            drive_d = plipnr_pkg::DrvIdle;
            unique case (field_q)
              plipnr_pkg::FS_LEN_LOW: begin
                plen_d  = {8'h00, rx_byte};
                field_d = plipnr_pkg::FS_LEN_HIGH;
                phase_d = plipnr_pkg::PH_WAIT_LOW;
                spin_d  = spin_limit_q;
              end
              plipnr_pkg::FS_LEN_HIGH: begin
                plen_d = plen_full;
                if ({1'b0, plen_full} > plen_limit) begin
                  fail = 1'b1;
                end else begin
                  field_d = (plen_full == 16'd0) ? plipnr_pkg::FS_CHECKSUM
                                                 : plipnr_pkg::FS_BODY;
                  phase_d = plipnr_pkg::PH_WAIT_LOW;
                  spin_d  = spin_limit_q;
                end
              end
              plipnr_pkg::FS_BODY: begin
                if (taken_q >= plipnr_pkg::HeaderLen) begin
                  valid_flag = 1'b1;
                  rx_val     = rx_byte;
                end
                taken_d = taken_inc;
                if (taken_inc >= plen_q) field_d = plipnr_pkg::FS_CHECKSUM;
                phase_d = plipnr_pkg::PH_WAIT_LOW;
                spin_d  = spin_limit_q;
              end
              default: begin
                // checksum byte: ignore value, close the packet
                if (plen_q <= plipnr_pkg::HeaderLen) begin
                  fail = 1'b1;
                end else begin
                  ok_end    = 1'b1;
                  err_cnt_d = 8'd0;
                  phase_d   = plipnr_pkg::PH_IDLE;
                end
              end
            endcase
          end else begin
            spin_d = spin_dec;
            fail   = (spin_dec == 16'd0);
          end
        end
        default: ;
      endcase
    end

    if (fail) begin
      drive_d = plipnr_pkg::DrvIdle;
      phase_d = plipnr_pkg::PH_IDLE;
      if (err_inc > {1'b0, error_limit_q}) begin
        offline_d = 1'b1;
        err_cnt_d = 8'd0;
      end else begin
        err_cnt_d = err_inc[7:0];
      end
    end
  end

  assign end_flag = fail | ok_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= plipnr_pkg::PH_IDLE;
      field_q   <= plipnr_pkg::FS_LEN_LOW;
      low_q     <= 8'd0;
      spin_q    <= 16'd0;
      plen_q    <= 16'd0;
      taken_q   <= 16'd0;
      err_cnt_q <= 8'd0;
      offline_q <= 1'b0;
      drive_q   <= 8'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      field_q   <= field_d;
      low_q     <= low_d;
      spin_q    <= spin_d;
      plen_q    <= plen_d;
      taken_q   <= taken_d;
      err_cnt_q <= err_cnt_d;
      offline_q <= offline_d;
      drive_q   <= drive_d;
    end
  end

  assign res_o.data_drive   = drive_d;
  assign res_o.rx_byte      = rx_val;
  assign res_o.byte_valid   = valid_flag;
  assign res_o.packet_end   = end_flag;
  assign res_o.packet_error = fail;
  assign res_o.busy_res     = (phase_d != plipnr_pkg::PH_IDLE);
  assign res_o.offline      = offline_d;

  assign stat_o.busy    = (phase_q != plipnr_pkg::PH_IDLE);
  assign stat_o.offline = offline_q;

endmodule

// ===== rtl/plipnr_out_reg.sv =====
`timescale 1ns / 1ps
module plipnr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  plipnr_pkg::res_t res_i,
  input  logic             take_i,
  output logic             free_o,
  output logic             valid_o,
  output plipnr_pkg::res_t res_o
);

  logic             valid_q;
  plipnr_pkg::res_t res_q;

  // Slot is free when empty or drained in this cycle.
  assign free_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/plip_nibble_receiver_core.sv =====
`timescale 1ns / 1ps
// PLIP nibble-mode receiver, compatible framing.
// Slave channel: one request per status poll. tuser = mode (0 status sample,
// 1 remote start), tdata = parallel port status byte (bit 7 shake, 6..3 nibble).
// Master channel: exactly one result per request. tlast = packet_end,
// tuser = byte_valid, tdata from bit 0: data_drive[7:0], rx_byte[15:8],
// packet_error, busy_res, offline, zero padding to 24 bits.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 spin_limit, 1 max_payload, 2 error_limit); index 3 is ignored.
// From request to result, the request lands in an input register, the
// sequencer evaluates it combinationally against the receiver state and the
// result goes to the output register.
// Throughput is one request per cycle while the master side takes results.
// When the master side stalls, the output register holds its result, the
// input register holds the next request, and s_axis_tready drops after that.
// Reset loads the default configuration, returns to idle and clears offline.
module plip_nibble_receiver_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // status_sample
  input  logic                            s_axis_tuser,   // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,   // data_drive, rx_byte,
                                                          // packet_error, busy_res,
                                                          // offline, pad
  output logic                            m_axis_tuser,   // byte_valid
  output logic                            m_axis_tlast,   // packet_end
  input  logic                            cfg_we_i,
  input  logic [plipnr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plipnr_pkg::CfgDataW-1:0] cfg_data_i
);

  logic             in_valid_q;
  logic             in_mode_q;
  logic [7:0]       in_sample_q;
  logic             advance, out_free;
  plipnr_pkg::res_t res_comb, res_out;
  plipnr_pkg::stat_t stat;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata;
    end
  end

  plipnr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .mode_i     (in_mode_q),
    .sample_i   (in_sample_q),
    .res_o      (res_comb),
    .stat_o     (stat)
  );

  plipnr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (res_comb),
    .take_i  (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {5'd0, res_out.offline, res_out.busy_res, res_out.packet_error,
                         res_out.rx_byte, res_out.data_drive};
  assign m_axis_tuser = res_out.byte_valid;
  assign m_axis_tlast = res_out.packet_end;

  // Offline always leaves the receiver idle.
  a_offline_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.offline |-> !stat.busy)
    else $error("receiver busy while offline");

  // Offline is sticky until reset.
  a_offline_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.offline |=> stat.offline)
    else $error("offline cleared without reset");

  // A result never carries a payload byte and a packet end together.
  a_byte_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_out.byte_valid && res_out.packet_end))
    else $error("payload byte flagged as packet end");

  // Errors are only reported at a packet end.
  a_err_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.packet_error |-> res_out.packet_end)
    else $error("packet error without packet end");

endmodule
